[rtl/qvr_pkg.sv]
`timescale 1ns / 1ps

package qvr_pkg;

  // field widths
  localparam int VecW     = 24;
  localparam int FracBits = 16;
  localparam int QuatW    = FracBits + 2;

  // first product stage: quaternion times vector
  localparam int P1W = QuatW + VecW;
  localparam int S1W = P1W + 2;
  localparam int TW  = S1W - FracBits;

  // second product stage: intermediate quaternion times conjugate
  localparam int P2W = TW + QuatW;
  localparam int S2W = P2W + 2;
  localparam int RW  = S2W - FracBits;

  typedef logic signed [QuatW-1:0] quat_t;
  typedef logic signed [VecW-1:0]  vec_t;
  typedef logic signed [P1W-1:0]   prod1_t;
  typedef logic signed [S1W-1:0]   sum1_t;
  typedef logic signed [TW-1:0]    tq_t;
  typedef logic signed [P2W-1:0]   prod2_t;
  typedef logic signed [S2W-1:0]   sum2_t;
  typedef logic signed [RW-1:0]    rnd2_t;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat4_t;

  // intermediate quaternion t = q * (0, v), with q carried along
  typedef struct packed {
    quat4_t q;
    tq_t    tw;
    tq_t    tx;
    tq_t    ty;
    tq_t    tz;
  } mid_t;

  // sign extension of products to sum width
  function automatic sum1_t ext1(prod1_t p);
    return {{(S1W-P1W){p[P1W-1]}}, p};
  endfunction

  function automatic sum2_t ext2(prod2_t p);
    return {{(S2W-P2W){p[P2W-1]}}, p};
  endfunction

  // round half up, then drop the fraction bits
  function automatic tq_t round1(sum1_t s);
    sum1_t r;
    r = s + (sum1_t'(1) << (FracBits - 1));
    return r[S1W-1:FracBits];
  endfunction

  function automatic rnd2_t round2(sum2_t s);
    sum2_t r;
    r = s + (sum2_t'(1) << (FracBits - 1));
    return r[S2W-1:FracBits];
  endfunction

endpackage

[rtl/qvr_if.sv]
`timescale 1ns / 1ps

// input channel: quaternion and vector
interface qvr_in_if;
  logic          valid;
  logic          ready;
  qvr_pkg::quat_t quat_w;
  qvr_pkg::quat_t quat_x;
  qvr_pkg::quat_t quat_y;
  qvr_pkg::quat_t quat_z;
  qvr_pkg::vec_t  vec_x;
  qvr_pkg::vec_t  vec_y;
  qvr_pkg::vec_t  vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

// output channel: rotated vector and clip flag
interface qvr_out_if;
  logic          valid;
  logic          ready;
  qvr_pkg::vec_t rot_x;
  qvr_pkg::vec_t rot_y;
  qvr_pkg::vec_t rot_z;
  logic          saturated;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated,
    output ready
  );
endinterface

[rtl/qvr_qv_prod.sv]
`timescale 1ns / 1ps

module qvr_qv_prod (
  input  logic           clk_i,
  input  logic           rst_ni,
  qvr_in_if.sink         in_i,
  output logic           mid_valid_o,
  input  logic           mid_ready_i,
  output qvr_pkg::mid_t  mid_o
);

  logic              a_valid_q;
  logic              b_valid_q;
  logic              a_en;
  logic              b_en;
  qvr_pkg::prod1_t   prod_d [12];
  qvr_pkg::prod1_t   prod_q [12];
  qvr_pkg::quat4_t   q_a_q;
  qvr_pkg::sum1_t    s_w;
  qvr_pkg::sum1_t    s_x;
  qvr_pkg::sum1_t    s_y;
  qvr_pkg::sum1_t    s_z;
  qvr_pkg::mid_t     mid_d;
  qvr_pkg::mid_t     mid_q;

  // a stage moves when it is empty or its successor moves
  assign b_en       = !b_valid_q || mid_ready_i;
  assign a_en       = !a_valid_q || b_en;
  assign in_i.ready = a_en;

  // stage a: the twelve partial products of q * (0, v)
  always_comb begin
    prod_d[0]  = in_i.quat_x * in_i.vec_x;
    prod_d[1]  = in_i.quat_y * in_i.vec_y;
    prod_d[2]  = in_i.quat_z * in_i.vec_z;
    prod_d[3]  = in_i.quat_w * in_i.vec_x;
    prod_d[4]  = in_i.quat_y * in_i.vec_z;
    prod_d[5]  = in_i.quat_z * in_i.vec_y;
    prod_d[6]  = in_i.quat_w * in_i.vec_y;
    prod_d[7]  = in_i.quat_z * in_i.vec_x;
    prod_d[8]  = in_i.quat_x * in_i.vec_z;
    prod_d[9]  = in_i.quat_w * in_i.vec_z;
    prod_d[10] = in_i.quat_x * in_i.vec_y;
    prod_d[11] = in_i.quat_y * in_i.vec_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_en) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      prod_q  <= prod_d;
      q_a_q.w <= in_i.quat_w;
      q_a_q.x <= in_i.quat_x;
      q_a_q.y <= in_i.quat_y;
      q_a_q.z <= in_i.quat_z;
    end
  end

  // stage b: sum and round to the intermediate quaternion
  always_comb begin
    s_w = -qvr_pkg::ext1(prod_q[0]) - qvr_pkg::ext1(prod_q[1])
          - qvr_pkg::ext1(prod_q[2]);
    s_x = qvr_pkg::ext1(prod_q[3]) + qvr_pkg::ext1(prod_q[4])
          - qvr_pkg::ext1(prod_q[5]);
    s_y = qvr_pkg::ext1(prod_q[6]) + qvr_pkg::ext1(prod_q[7])
          - qvr_pkg::ext1(prod_q[8]);
    s_z = qvr_pkg::ext1(prod_q[9]) + qvr_pkg::ext1(prod_q[10])
          - qvr_pkg::ext1(prod_q[11]);
    mid_d.q  = q_a_q;
    mid_d.tw = qvr_pkg::round1(s_w);
    mid_d.tx = qvr_pkg::round1(s_x);
    mid_d.ty = qvr_pkg::round1(s_y);
    mid_d.tz = qvr_pkg::round1(s_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = b_valid_q;
  assign mid_o       = mid_q;

endmodule

[rtl/qvr_tq_prod.sv]
`timescale 1ns / 1ps

module qvr_tq_prod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mid_valid_i,
  output logic           mid_ready_o,
  input  qvr_pkg::mid_t  mid_i,
  qvr_out_if.source      out_o
);

  logic              c_valid_q;
  logic              d_valid_q;
  logic              c_en;
  logic              d_en;
  qvr_pkg::prod2_t   prod_d [12];
  qvr_pkg::prod2_t   prod_q [12];
  qvr_pkg::rnd2_t    r_x;
  qvr_pkg::rnd2_t    r_y;
  qvr_pkg::rnd2_t    r_z;
  logic              ok_x;
  logic              ok_y;
  logic              ok_z;
  qvr_pkg::vec_t     rot_x_d;
  qvr_pkg::vec_t     rot_y_d;
  qvr_pkg::vec_t     rot_z_d;
  logic              sat_d;
  qvr_pkg::vec_t     rot_x_q;
  qvr_pkg::vec_t     rot_y_q;
  qvr_pkg::vec_t     rot_z_q;
  qvr_pkg::vec_t     vec_max;
  qvr_pkg::vec_t     vec_min;
  logic              sat_q;

  assign d_en        = !d_valid_q || out_o.ready;
  assign c_en        = !c_valid_q || d_en;
  assign mid_ready_o = c_en;

  // stage c: partial products of t * conj(q), vector part only
  always_comb begin
    prod_d[0]  = mid_i.tx * mid_i.q.w;
    prod_d[1]  = mid_i.tw * mid_i.q.x;
    prod_d[2]  = mid_i.ty * mid_i.q.z;
    prod_d[3]  = mid_i.tz * mid_i.q.y;
    prod_d[4]  = mid_i.ty * mid_i.q.w;
    prod_d[5]  = mid_i.tw * mid_i.q.y;
    prod_d[6]  = mid_i.tz * mid_i.q.x;
    prod_d[7]  = mid_i.tx * mid_i.q.z;
    prod_d[8]  = mid_i.tz * mid_i.q.w;
    prod_d[9]  = mid_i.tw * mid_i.q.z;
    prod_d[10] = mid_i.tx * mid_i.q.y;
    prod_d[11] = mid_i.ty * mid_i.q.x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_en) begin
      c_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      prod_q <= prod_d;
    end
  end

  // stage d: sum, round and saturate to the vector width
  assign vec_max = {1'b0, {(qvr_pkg::VecW-1){1'b1}}};
  assign vec_min = {1'b1, {(qvr_pkg::VecW-1){1'b0}}};

  always_comb begin
    r_x = qvr_pkg::round2(qvr_pkg::ext2(prod_q[0]) - qvr_pkg::ext2(prod_q[1])
                          - qvr_pkg::ext2(prod_q[2]) + qvr_pkg::ext2(prod_q[3]));
    r_y = qvr_pkg::round2(qvr_pkg::ext2(prod_q[4]) - qvr_pkg::ext2(prod_q[5])
                          - qvr_pkg::ext2(prod_q[6]) + qvr_pkg::ext2(prod_q[7]));
    r_z = qvr_pkg::round2(qvr_pkg::ext2(prod_q[8]) - qvr_pkg::ext2(prod_q[9])
                          - qvr_pkg::ext2(prod_q[10]) + qvr_pkg::ext2(prod_q[11]));
    // in range when the sign bit and all bits above it agree
    ok_x = (&r_x[qvr_pkg::RW-1:qvr_pkg::VecW-1]) || !(|r_x[qvr_pkg::RW-1:qvr_pkg::VecW-1]);
    ok_y = (&r_y[qvr_pkg::RW-1:qvr_pkg::VecW-1]) || !(|r_y[qvr_pkg::RW-1:qvr_pkg::VecW-1]);
    ok_z = (&r_z[qvr_pkg::RW-1:qvr_pkg::VecW-1]) || !(|r_z[qvr_pkg::RW-1:qvr_pkg::VecW-1]);
    rot_x_d = ok_x ? r_x[qvr_pkg::VecW-1:0] : (r_x[qvr_pkg::RW-1] ? vec_min : vec_max);
    rot_y_d = ok_y ? r_y[qvr_pkg::VecW-1:0] : (r_y[qvr_pkg::RW-1] ? vec_min : vec_max);
    rot_z_d = ok_z ? r_z[qvr_pkg::VecW-1:0] : (r_z[qvr_pkg::RW-1] ? vec_min : vec_max);
    sat_d   = !(ok_x && ok_y && ok_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en) begin
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
      rot_z_q <= rot_z_d;
      sat_q   <= sat_d;
    end
  end

  assign out_o.valid     = d_valid_q;
  assign out_o.rot_x     = rot_x_q;
  assign out_o.rot_y     = rot_y_q;
  assign out_o.rot_z     = rot_z_q;
  assign out_o.saturated = sat_q;

endmodule

[rtl/quaternion_vector_rotate.sv]
`timescale 1ns / 1ps

// Rotates a vector by a quaternion: r = q * (0, v) * conj(q), vector part.
// Input channel in_i carries the Q1.16 quaternion quat_w..quat_z and the
// signed vector vec_x..vec_z; output channel out_o carries rot_x..rot_z and
// the saturated flag, set when any component was clipped to 24 bits.
// The quaternion is used as given, so a non-unit q also scales the vector.
// Both channels transfer on a rising edge with valid and ready high.
// The stages are products of q * v, sum and round to t, products of
// t * conj(q), sum/round/saturate; out_o is driven from the last stage.
// One item per cycle passes while out_o.ready is high; the four register
// stages each hold one item and carry their own valid bit.
// When the receiver holds ready low, the stages in front of the stalled
// result keep filling their empty slots; in_i.ready drops only once every
// stage holds an item. No item is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
module quaternion_vector_rotate (
  input  logic       clk_i,
  input  logic       rst_ni,
  qvr_in_if.sink     in_i,
  qvr_out_if.source  out_o
);

  logic           mid_valid;
  logic           mid_ready;
  qvr_pkg::mid_t  mid_data;

  // first Hamilton product: t = q * (0, v)
  qvr_qv_prod u_qv_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid_data)
  );

  // second Hamilton product: r = t * conj(q), saturated
  qvr_tq_prod u_tq_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid_data),
    .out_o       (out_o)
  );

endmodule
